FILE: hw/rtl/softmax_topk_select_core_defines.svh
// ----------------------------------------------------------------------------
// Softmax top-k select: assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_TOPK_SELECT_CORE_DEFINES_SVH
`define SOFTMAX_TOPK_SELECT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port check failed");

// The consequent must hold in the cycle after the antecedent.
`define STK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

FILE: hw/rtl/stk_pkg.sv
// ----------------------------------------------------------------------------
// Softmax top-k select package
// Shared widths, constants, cell control type and the exponent table.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int unsigned SCORE_W = 16;
  localparam int unsigned E_W     = 17;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned RANK_W  = 3;
  localparam int unsigned TOPK_W  = 4;

  localparam logic [16:0]        LOG2E_Q16  = 17'd94548;
  localparam logic [E_W-1:0]     E_ONE      = 17'd65536;
  localparam logic [SCORE_W-1:0] SCORE_MIN  = 16'h8000;
  localparam logic [TOPK_W-1:0]  TOPK_RESET = 4'd5;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  // round(2^(-2^-(i+1)) * 65536)
  function automatic logic [15:0] exp_frac_c(input logic [2:0] i);
    logic [15:0] c;
    case (i)
      3'd0:    c = 16'd46341;
      3'd1:    c = 16'd55109;
      3'd2:    c = 16'd60097;
      3'd3:    c = 16'd62757;
      3'd4:    c = 16'd64132;
      3'd5:    c = 16'd64830;
      3'd6:    c = 16'd65182;
      3'd7:    c = 16'd65359;
      default: c = 16'd65359;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/stk_cell.sv
// ----------------------------------------------------------------------------
// Softmax top-k select: ranking cell
// Holds one entry of the sorted list; shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
module stk_cell #(
  parameter int unsigned IDX_W = 10
) (
  input  logic                               clk,
  input  stk_pkg::cell_ctrl_t                ctrl,
  input  logic                               occupied,
  input  logic signed [stk_pkg::SCORE_W-1:0] new_score,
  input  logic [IDX_W-1:0]                   new_index,
  input  logic                               take_in,
  input  logic signed [stk_pkg::SCORE_W-1:0] prev_score,
  input  logic [IDX_W-1:0]                   prev_index,
  input  logic signed [stk_pkg::SCORE_W-1:0] next_score,
  input  logic [IDX_W-1:0]                   next_index,
  output logic                               take_out,
  output logic signed [stk_pkg::SCORE_W-1:0] score,
  output logic [IDX_W-1:0]                   index
);

  logic signed [stk_pkg::SCORE_W-1:0] score_r;
  logic [IDX_W-1:0]                   index_r;

  // Equal scores stay ahead, so the earlier index keeps its place.
  assign take_out = !occupied || (new_score > score_r);
  assign score    = score_r;
  assign index    = index_r;

  always_ff @(posedge clk) begin
    if (ctrl.ins && take_out) begin
      score_r <= take_in ? prev_score : new_score;
      index_r <= take_in ? prev_index : new_index;
    end else if (ctrl.pop) begin
      score_r <= next_score;
      index_r <= next_index;
    end
  end

endmodule

FILE: hw/rtl/stk_exp.sv
// ----------------------------------------------------------------------------
// Softmax top-k select: fixed-point exponential
// E(-t) in Q1.16 for t in Q8.8, one fraction bit per cycle.
// ----------------------------------------------------------------------------
module stk_exp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [stk_pkg::SCORE_W-1:0] t,
  output logic                        done,
  output logic [stk_pkg::E_W-1:0]     e
);

  typedef enum logic [1:0] {E_IDLE, E_STEP, E_FIN} exp_state_t;

  exp_state_t             state_r;
  logic [24:0]            y_r;
  logic [stk_pkg::E_W-1:0] r_r;
  logic [2:0]             step_r;
  logic                   done_r;
  logic [stk_pkg::E_W-1:0] e_r;

  logic [32:0]            y_full;
  logic [32:0]            r_prod;
  logic [8:0]             n_w;
  logic [7:0]             f_w;

  assign y_full = 33'(t) * 33'(stk_pkg::LOG2E_Q16);
  assign n_w    = y_r[24:16];
  assign f_w    = y_r[15:8];
  assign r_prod = 33'(r_r) * 33'(stk_pkg::exp_frac_c(step_r)) + 33'd32768;

  assign done = done_r;
  assign e    = e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        E_IDLE: begin
          if (start) begin
            y_r     <= y_full[32:8];
            r_r     <= stk_pkg::E_ONE;
            step_r  <= '0;
            state_r <= E_STEP;
          end
        end
        E_STEP: begin
          if (f_w[3'd7 - step_r]) begin
            r_r <= r_prod[32:16];
          end
          step_r <= step_r + 3'd1;
          if (step_r == 3'd7) begin
            state_r <= E_FIN;
          end
        end
        E_FIN: begin
          e_r     <= (n_w > 9'd16) ? '0 : (r_r >> n_w[4:0]);
          done_r  <= 1'b1;
          state_r <= E_IDLE;
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/softmax_topk_select_core.sv
// After acceptance a score keeps busy high through the exponential unit (one fraction bit
// per cycle) and rescale multiply; an ignored non-last score passes the skip state only.
// After the last score each result strobes at the end of the exponential plus a 33-step
// restoring divider, and the next result starts once the head cell has been popped.
// A new score is accepted only while busy is low; results cannot be stalled. Reset (rst_n,
// synchronous, low) clears the set state and sets top_count to 5; cells need no clearing.
// ----------------------------------------------------------------------------
// Softmax top-k select core
// Online softmax sum with a chain of ranking cells for the best scores.
// ----------------------------------------------------------------------------
module softmax_topk_select_core #(
  parameter int unsigned MAX_K      = 8,
  parameter int unsigned MAX_SCORES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [stk_pkg::SCORE_W-1:0] in_score,
  input  logic                               in_last_score,
  output logic                               out_valid,
  output logic [stk_pkg::INDEX_W-1:0]        out_class_index,
  output logic [stk_pkg::PROB_W-1:0]         out_probability,
  output logic [stk_pkg::RANK_W-1:0]         out_rank,
  output logic                               out_last_result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [1:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned IDX_W  = (MAX_SCORES > 2) ? $clog2(MAX_SCORES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SCORES + 1);
  localparam int unsigned HELD_W = $clog2(MAX_K + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SKIP, S_EXP, S_ACC, S_OUT, S_OEXP, S_DIV, S_POP
  } core_state_t;

  core_state_t                        state_r;
  logic [stk_pkg::TOPK_W-1:0]         top_count_r;
  logic signed [stk_pkg::SCORE_W-1:0] max_r;
  logic [stk_pkg::SUM_W-1:0]          sum_r;
  logic [CNT_W-1:0]                   count_r;
  logic [HELD_W-1:0]                  held_r;
  logic [HELD_W-1:0]                  rank_r;
  logic signed [stk_pkg::SCORE_W-1:0] score_r;
  logic                               last_r;
  logic                               grow_r;
  logic [48:0]                        prod_r;
  logic [32:0]                        num_r;
  logic [32:0]                        rem_r;
  logic [32:0]                        quo_r;
  logic [5:0]                         div_cnt_r;
  logic                               out_valid_r;
  logic [stk_pkg::INDEX_W-1:0]        out_index_r;
  logic [stk_pkg::PROB_W-1:0]         out_prob_r;
  logic [stk_pkg::RANK_W-1:0]         out_rank_r;
  logic                               out_last_r;

  logic                               accept;
  logic                               take;
  logic signed [stk_pkg::SCORE_W:0]   diff;
  logic                               grow;
  logic                               exp_start;
  logic [stk_pkg::SCORE_W-1:0]        exp_t;
  logic                               exp_done;
  logic [stk_pkg::E_W-1:0]            exp_e;
  logic signed [stk_pkg::SCORE_W:0]   head_diff;
  logic [32:0]                        rounded;
  logic [33:0]                        grown_sum;
  logic [32:0]                        added_sum;
  logic [stk_pkg::SUM_W-1:0]          sum_nxt;
  logic [32:0]                        rem_sh;
  logic                               rem_ge;
  logic [32:0]                        quo_nxt;
  logic [31:0]                        k_eff;
  logic [HELD_W-1:0]                  nres;
  logic [31:0]                        head_idx_ext;
  logic [31:0]                        rank_ext;

  stk_pkg::cell_ctrl_t                cell_ctrl;
  logic signed [stk_pkg::SCORE_W-1:0] cell_score [MAX_K];
  logic [IDX_W-1:0]                   cell_index [MAX_K];
  logic                               cell_take  [MAX_K];
  logic [IDX_W-1:0]                   new_index;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign take   = (32'(count_r) < MAX_SCORES);
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(top_count_r) : 32'd0;

  assign grow      = in_score > max_r;
  assign diff      = grow ? (17'(in_score) - 17'(max_r)) : (17'(max_r) - 17'(in_score));
  assign head_diff = 17'(max_r) - 17'(cell_score[0]);
  assign new_index = count_r[IDX_W-1:0];

  assign exp_start = (accept && take) || (state_r == S_OUT && rank_r != nres);
  assign exp_t     = (state_r == S_OUT) ? head_diff[stk_pkg::SCORE_W-1:0]
                                        : diff[stk_pkg::SCORE_W-1:0];

  assign cell_ctrl.ins = accept && take;
  assign cell_ctrl.pop = (state_r == S_POP);

  // Online sum: rescale by E(old max - new max) when the maximum rises.
  assign rounded   = 33'((prod_r + 49'd32768) >> 16);
  assign grown_sum = 34'(rounded) + 34'(stk_pkg::E_ONE);
  assign added_sum = 33'(sum_r) + 33'(prod_r[stk_pkg::E_W-1:0]);
  always_comb begin
    if (grow_r) begin
      sum_nxt = (grown_sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown_sum[31:0];
    end else begin
      sum_nxt = added_sum[32] ? 32'hFFFF_FFFF : added_sum[31:0];
    end
  end

  assign rem_sh  = {rem_r[31:0], num_r[32]};
  assign rem_ge  = rem_sh >= {1'b0, sum_r};
  assign quo_nxt = {quo_r[31:0], rem_ge};

  always_comb begin
    k_eff = (top_count_r == '0) ? 32'd1 : 32'(top_count_r);
    if (k_eff > MAX_K) begin
      k_eff = MAX_K;
    end
    nres = (k_eff < 32'(held_r)) ? HELD_W'(k_eff) : held_r;
  end

  assign head_idx_ext = 32'(cell_index[0]);
  assign rank_ext     = 32'(rank_r);

  stk_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (exp_start),
    .t     (exp_t),
    .done  (exp_done),
    .e     (exp_e)
  );

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic signed [stk_pkg::SCORE_W-1:0] prev_s;
    logic [IDX_W-1:0]                   prev_i;
    logic                               prev_t;
    logic signed [stk_pkg::SCORE_W-1:0] next_s;
    logic [IDX_W-1:0]                   next_i;
    if (i == 0) begin : g_head
      assign prev_s = cell_score[0];
      assign prev_i = cell_index[0];
      assign prev_t = 1'b0;
    end else begin : g_body
      assign prev_s = cell_score[i-1];
      assign prev_i = cell_index[i-1];
      assign prev_t = cell_take[i-1];
    end
    if (i == MAX_K - 1) begin : g_tail
      assign next_s = cell_score[i];
      assign next_i = cell_index[i];
    end else begin : g_mid
      assign next_s = cell_score[i+1];
      assign next_i = cell_index[i+1];
    end
    stk_cell #(.IDX_W(IDX_W)) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .occupied   (32'(held_r) > i),
      .new_score  (in_score),
      .new_index  (new_index),
      .take_in    (prev_t),
      .prev_score (prev_s),
      .prev_index (prev_i),
      .next_score (next_s),
      .next_index (next_i),
      .take_out   (cell_take[i]),
      .score      (cell_score[i]),
      .index      (cell_index[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= stk_pkg::TOPK_RESET;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      top_count_r <= pwdata[stk_pkg::TOPK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= stk_pkg::SCORE_MIN;
      sum_r       <= '0;
      count_r     <= '0;
      held_r      <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            score_r <= in_score;
            last_r  <= in_last_score;
            grow_r  <= grow;
            if (take) begin
              count_r <= count_r + CNT_W'(1);
              if (held_r != HELD_W'(MAX_K)) begin
                held_r <= held_r + HELD_W'(1);
              end
              state_r <= S_EXP;
            end else begin
              state_r <= in_last_score ? S_OUT : S_SKIP;
            end
          end
        end
        S_SKIP: state_r <= S_IDLE;
        S_EXP: begin
          if (exp_done) begin
            prod_r  <= grow_r ? (49'(sum_r) * 49'(exp_e)) : 49'(exp_e);
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          sum_r <= sum_nxt;
          if (grow_r) begin
            max_r <= score_r;
          end
          state_r <= last_r ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (rank_r == nres) begin
            max_r   <= stk_pkg::SCORE_MIN;
            sum_r   <= '0;
            count_r <= '0;
            held_r  <= '0;
            rank_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_OEXP;
          end
        end
        S_OEXP: begin
          if (exp_done) begin
            num_r     <= {exp_e, 16'd0};
            rem_r     <= '0;
            quo_r     <= '0;
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          num_r     <= {num_r[31:0], 1'b0};
          rem_r     <= rem_ge ? (rem_sh - {1'b0, sum_r}) : rem_sh;
          quo_r     <= quo_nxt;
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'd32) begin
            out_valid_r <= 1'b1;
            out_index_r <= head_idx_ext[stk_pkg::INDEX_W-1:0];
            out_prob_r  <= (quo_nxt > 33'h0FFFF) ? 16'hFFFF : quo_nxt[15:0];
            out_rank_r  <= rank_ext[stk_pkg::RANK_W-1:0];
            out_last_r  <= (rank_r + HELD_W'(1)) == nres;
            state_r     <= S_POP;
          end
        end
        S_POP: begin
          rank_r  <= rank_r + HELD_W'(1);
          state_r <= S_OUT;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_class_index = out_index_r;
  assign out_probability = out_prob_r;
  assign out_rank        = out_rank_r;
  assign out_last_result = out_last_r;

endmodule

FILE: hw/rtl/stk_checker.sv
// ----------------------------------------------------------------------------
// Softmax top-k select: port checker
// Watches the top-level ports for ordering of beats and busy handling.
// ----------------------------------------------------------------------------
`include "softmax_topk_select_core_defines.svh"

module stk_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic [2:0] out_rank
);

  // A result beat only appears while an item is being processed.
  `STK_ASSERT_NOW(a_valid_busy, out_valid, busy)
  // An accepted item always makes the block busy in the cycle after acceptance.
  `STK_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Beats are spaced apart, so no two result beats are adjacent.
  `STK_ASSERT_NEXT(a_beat_gap, out_valid, !out_valid)
  // A result beat that directly follows an idle block must carry rank 0.
  `STK_ASSERT_NOW(a_first_rank, out_valid && !$past(busy), out_rank == 3'd0)

endmodule

bind softmax_topk_select_core stk_checker u_stk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_rank        (out_rank)
);
